>>> src/dpd_pkg.sv
`timescale 1ns / 1ps

package dpd_pkg;

	// Signed Q48.16 working word, saturated to +-(2^62-1).
	typedef logic signed [63:0] wide_t;
	// Narrow multiplier operand; its magnitude stays below 2^33.
	typedef logic signed [33:0] narrow_t;
	// Sine or cosine in Q2.16, range -1.0 .. +1.0.
	typedef logic signed [17:0] trig_t;
	typedef logic [1:0] cfg_index_t;

	localparam cfg_index_t CFG_LENGTH_ONE = 2'd0;
	localparam cfg_index_t CFG_LENGTH_TWO = 2'd1;
	localparam cfg_index_t CFG_MASS_ONE = 2'd2;
	localparam cfg_index_t CFG_MASS_TWO = 2'd3;

	localparam logic [23:0] CFG_RESET = 24'd65536;
	localparam logic [19:0] GRAVITY = 20'd642908;
	// round(2^32 / (2*pi)): radians to a 16-bit phase.
	localparam logic [29:0] PHASE_K = 30'd683565276;

	localparam wide_t WMAX = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] WMAX65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;

	// Latencies of the building blocks, in cycles.
	localparam int MUL_LAT = 2;
	localparam int SC_LAT = 5;
	localparam int DIV_STEPS = 32;
	localparam int DIV_LAT = DIV_STEPS + 2;

	// Pipeline stage at which each group of values sits in a register.
	localparam int T_IN = 1;
	localparam int T_PH = T_IN + 1;
	localparam int T_SQ = T_IN + MUL_LAT;
	localparam int T_SC = T_PH + SC_LAT;
	localparam int T_P1 = T_SC + MUL_LAT;
	localparam int T_P2 = T_P1 + MUL_LAT;
	localparam int T_RHS = T_P2 + 1;
	localparam int T_P3 = T_RHS + MUL_LAT;
	localparam int T_NUM = T_P3 + 1;
	localparam int T_OUT = T_NUM + DIV_LAT;

	function automatic wide_t sat65(input logic signed [64:0] v);
		wide_t r;
		if (v > WMAX65) begin
			r = WMAX;
		end else if (v < -WMAX65) begin
			r = -WMAX;
		end else begin
			r = v[63:0];
		end
		return r;
	endfunction

	function automatic wide_t add_sat(input wide_t a, input wide_t b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		return sat65(s);
	endfunction

	function automatic wide_t sub_sat(input wide_t a, input wide_t b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		return sat65(s);
	endfunction

	// Angle in Q16.16 radians to a phase in units of 2*pi/65536.
	function automatic logic [15:0] to_phase(input logic signed [31:0] a);
		logic signed [63:0] pr;
		logic [63:0] pq;
		pr = 64'(a) * $signed({34'd0, PHASE_K});
		pq = pr + 64'h0000_0000_8000_0000;
		return pq[47:32];
	endfunction

endpackage

>>> src/dpd_qmul.sv
`timescale 1ns / 1ps

// Q48.16 multiply, rounded half away from zero and saturated.
// The wide operand is split in two 31-bit halves; the partial products are
// registered and summed in the second stage.
module dpd_qmul (
	input  logic            clk,
	input  logic            en,
	input  dpd_pkg::narrow_t a,
	input  dpd_pkg::wide_t   b,
	output dpd_pkg::wide_t   y
);

	logic [32:0] am;
	logic [61:0] bm;
	logic [63:0] plo_s1;
	logic [63:0] phi_s1;
	logic        neg_s1;
	logic [95:0] full;
	logic [61:0] mag;

	always_comb begin
		am = a[33] ? 33'(-a) : a[32:0];
		bm = b[63] ? 62'(-b) : b[61:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1 <= am * bm[30:0];
			phi_s1 <= am * bm[61:31];
			neg_s1 <= a[33] ^ b[63];
		end
	end

	always_comb begin
		full = 96'({phi_s1, 31'd0}) + 96'(plo_s1) + 96'h8000;
		if (full[95:16] > 80'h3FFF_FFFF_FFFF_FFFF) begin
			mag = '1;
		end else begin
			mag = full[77:16];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y <= neg_s1 ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
		end
	end

endmodule

>>> src/dpd_sincos.sv
`timescale 1ns / 1ps

// Sine and cosine of a 16-bit phase. Two lanes evaluate the quarter-wave
// polynomial for t and for 16384-t: a squaring stage, then one Horner step per stage.
module dpd_sincos (
	input  logic           clk,
	input  logic           en,
	input  logic [15:0]    phase,
	output dpd_pkg::trig_t sin_val,
	output dpd_pkg::trig_t cos_val
);

	localparam logic [30:0] C1 = 31'd1686629713;
	localparam logic [30:0] C3 = 31'd693598668;
	localparam logic [30:0] C5 = 31'd85569306;
	localparam logic [30:0] C7 = 31'd5027025;

	logic [14:0] tl [0:1];
	logic [30:0] xl [0:1];
	logic [61:0] sq [0:1];
	logic [61:0] pr2 [0:1];
	logic [61:0] pr3 [0:1];
	logic [61:0] pr4 [0:1];
	logic [61:0] pr5 [0:1];
	logic [32:0] vr [0:1];
	logic [16:0] mag [0:1];

	logic [30:0] x_s1 [0:1];
	logic [30:0] x2_s1 [0:1];
	logic [1:0]  quad_s1;
	logic [30:0] x_s2 [0:1];
	logic [30:0] x2_s2 [0:1];
	logic [30:0] p_s2 [0:1];
	logic [1:0]  quad_s2;
	logic [30:0] x_s3 [0:1];
	logic [30:0] x2_s3 [0:1];
	logic [30:0] p_s3 [0:1];
	logic [1:0]  quad_s3;
	logic [30:0] x_s4 [0:1];
	logic [30:0] p_s4 [0:1];
	logic [1:0]  quad_s4;

	dpd_pkg::trig_t av;
	dpd_pkg::trig_t bv;

	always_comb begin
		tl[0] = {1'b0, phase[13:0]};
		tl[1] = 15'd16384 - {1'b0, phase[13:0]};
		for (int i = 0; i < 2; i++) begin
			xl[i] = {tl[i], 16'd0};
			sq[i] = 62'(xl[i]) * 62'(xl[i]);
			pr2[i] = 62'(x2_s1[i]) * 62'(C7);
			pr3[i] = 62'(x2_s2[i]) * 62'(p_s2[i]);
			pr4[i] = 62'(x2_s3[i]) * 62'(p_s3[i]);
			pr5[i] = 62'(x_s4[i]) * 62'(p_s4[i]);
			vr[i] = 33'(pr5[i][61:30]) + 33'h2000;
			if (vr[i][32:14] > 19'd65536) begin
				mag[i] = 17'd65536;
			end else begin
				mag[i] = vr[i][30:14];
			end
		end
		av = $signed({1'b0, mag[0]});
		bv = $signed({1'b0, mag[1]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				x_s1[i] <= xl[i];
				x2_s1[i] <= sq[i][60:30];
				x_s2[i] <= x_s1[i];
				x2_s2[i] <= x2_s1[i];
				p_s2[i] <= C5 - pr2[i][60:30];
				x_s3[i] <= x_s2[i];
				x2_s3[i] <= x2_s2[i];
				p_s3[i] <= C3 - pr3[i][60:30];
				x_s4[i] <= x_s3[i];
				p_s4[i] <= C1 - pr4[i][60:30];
			end
			quad_s1 <= phase[15:14];
			quad_s2 <= quad_s1;
			quad_s3 <= quad_s2;
			quad_s4 <= quad_s3;
			unique case (quad_s4)
				2'd0: begin
					sin_val <= av;
					cos_val <= bv;
				end
				2'd1: begin
					sin_val <= bv;
					cos_val <= -av;
				end
				2'd2: begin
					sin_val <= -av;
					cos_val <= -bv;
				end
				default: begin
					sin_val <= -bv;
					cos_val <= av;
				end
			endcase
		end
	end

endmodule

>>> src/dpd_div.sv
`timescale 1ns / 1ps

// Q16.16 divide, truncated toward zero and saturated to 32 bits.
// Overflow is decided up front; then one restoring step per stage.
module dpd_div (
	input  logic                clk,
	input  logic                en,
	input  dpd_pkg::wide_t      num,
	input  dpd_pkg::wide_t      den,
	output logic signed [31:0]  quo
);

	typedef struct packed {
		logic neg;
		logic zero;
		logic ovf;
	} div_flags_t;

	logic [61:0] nm;
	logic [61:0] dm;
	logic [61:0] rem_s [0:dpd_pkg::DIV_STEPS];
	logic [31:0] low_s [0:dpd_pkg::DIV_STEPS];
	logic [31:0] q_s [0:dpd_pkg::DIV_STEPS];
	logic [61:0] d_s [0:dpd_pkg::DIV_STEPS];
	div_flags_t  fl_s [0:dpd_pkg::DIV_STEPS];
	logic [62:0] trial [1:dpd_pkg::DIV_STEPS];
	logic        ge [1:dpd_pkg::DIV_STEPS];
	div_flags_t  fin;
	logic [31:0] qf;

	always_comb begin
		nm = num[63] ? 62'(-num) : num[61:0];
		dm = den[63] ? 62'(-den) : den[61:0];
		for (int i = 1; i <= dpd_pkg::DIV_STEPS; i++) begin
			trial[i] = {rem_s[i-1], low_s[i-1][31]};
			ge[i] = trial[i] >= {1'b0, d_s[i-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {16'd0, nm[61:16]};
			low_s[0] <= {nm[15:0], 16'd0};
			q_s[0] <= '0;
			d_s[0] <= dm;
			fl_s[0].neg <= num[63] ^ den[63];
			fl_s[0].zero <= (num == '0);
			fl_s[0].ovf <= {16'd0, nm} >= {dm, 16'd0};
			for (int i = 1; i <= dpd_pkg::DIV_STEPS; i++) begin
				rem_s[i] <= ge[i] ? 62'(trial[i] - {1'b0, d_s[i-1]}) : trial[i][61:0];
				low_s[i] <= {low_s[i-1][30:0], 1'b0};
				q_s[i] <= {q_s[i-1][30:0], ge[i]};
				d_s[i] <= d_s[i-1];
				fl_s[i] <= fl_s[i-1];
			end
		end
	end

	always_comb begin
		fin = fl_s[dpd_pkg::DIV_STEPS];
		qf = q_s[dpd_pkg::DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (fin.zero) begin
				quo <= '0;
			end else if (fin.neg) begin
				if (fin.ovf || qf > 32'h8000_0000) begin
					quo <= 32'sh8000_0000;
				end else begin
					quo <= -$signed(qf);
				end
			end else begin
				if (fin.ovf || qf > 32'h7FFF_FFFF) begin
					quo <= 32'sh7FFF_FFFF;
				end else begin
					quo <= $signed(qf);
				end
			end
		end
	end

endmodule

>>> src/double_pendulum_derivative.sv
`timescale 1ns / 1ps

// Channel | Signals                                        | Beat
// --------+------------------------------------------------+------------------------------
// in      | in_valid, in_ready, angle_1..torque_2          | one pendulum state and torques
// out     | out_valid, out_ready, out_rate_1..accel_2      | one state derivative
// cfg     | cfg_we, cfg_index, cfg_data                    | one register write
//
// One beat is taken every cycle unless the output stalls. A beat accepted into the
// first stage moves down the register chain and waits in the output stage until taken.
// Its path runs through the five-stage sine chain, the three multiply levels and
// the 32-step restoring divider that follows them.
// Reset sets both lengths and both masses to 1.0 and empties the pipeline.
// While the output beat waits, the whole pipeline holds and in_ready is low.

module double_pendulum_derivative (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  angle_1,
	input  logic signed [31:0]  rate_1,
	input  logic signed [31:0]  angle_2,
	input  logic signed [31:0]  rate_2,
	input  logic signed [31:0]  torque_1,
	input  logic signed [31:0]  torque_2,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  out_rate_1,
	output logic signed [31:0]  accel_1,
	output logic signed [31:0]  out_rate_2,
	output logic signed [31:0]  accel_2,
	input  logic                cfg_we,
	input  dpd_pkg::cfg_index_t cfg_index,
	input  logic [23:0]         cfg_data
);

	// Configuration registers.
	logic [23:0] length_one_q;
	logic [23:0] length_two_q;
	logic [23:0] mass_one_q;
	logic [23:0] mass_two_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_one_q <= dpd_pkg::CFG_RESET;
			length_two_q <= dpd_pkg::CFG_RESET;
			mass_one_q <= dpd_pkg::CFG_RESET;
			mass_two_q <= dpd_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpd_pkg::CFG_LENGTH_ONE: length_one_q <= cfg_data;
				dpd_pkg::CFG_LENGTH_TWO: length_two_q <= cfg_data;
				dpd_pkg::CFG_MASS_ONE: mass_one_q <= cfg_data;
				dpd_pkg::CFG_MASS_TWO: mass_two_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Products of the registers alone. They follow a write, msumg_q by way of
	// msum_q, long before any beat accepted after the write reaches them.
	logic [24:0] msum_q;
	logic [32:0] m2l2_q;
	logic [32:0] m2l1_q;
	logic [29:0] msumg_q;
	logic [28:0] m2g_q;
	logic [48:0] m2l2_full;
	logic [48:0] m2l1_full;
	logic [45:0] msumg_full;
	logic [44:0] m2g_full;
	logic [24:0] msum_now;

	always_comb begin
		msum_now = {1'b0, mass_one_q} + {1'b0, mass_two_q};
		m2l2_full = 49'(mass_two_q) * 49'(length_two_q) + 49'h8000;
		m2l1_full = 49'(mass_two_q) * 49'(length_one_q) + 49'h8000;
		msumg_full = 46'(msum_q) * 46'(dpd_pkg::GRAVITY) + 46'h8000;
		m2g_full = 45'(mass_two_q) * 45'(dpd_pkg::GRAVITY) + 45'h8000;
	end

	always_ff @(posedge clk) begin
		msum_q <= msum_now;
		m2l2_q <= m2l2_full[48:16];
		m2l1_q <= m2l1_full[48:16];
		msumg_q <= msumg_full[45:16];
		m2g_q <= m2g_full[44:16];
	end

	// Pipeline advance: everything moves unless the last stage holds a beat
	// that the output side has not taken.
	logic [dpd_pkg::T_OUT:1] vld_s;
	logic en;

	assign en = !vld_s[dpd_pkg::T_OUT] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_s[dpd_pkg::T_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[dpd_pkg::T_OUT-1:1], in_valid};
		end
	end

	// Input registers and the lines that carry rates and torques along.
	logic signed [31:0] ang1_s1;
	logic signed [31:0] ang2_s1;
	logic signed [31:0] rate1_s [dpd_pkg::T_IN:dpd_pkg::T_OUT];
	logic signed [31:0] rate2_s [dpd_pkg::T_IN:dpd_pkg::T_OUT];
	logic signed [31:0] torq1_s [dpd_pkg::T_IN:dpd_pkg::T_P1];
	logic signed [31:0] torq2_s [dpd_pkg::T_IN:dpd_pkg::T_P1];
	logic [15:0] ph1_s2;
	logic [15:0] ph2_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ang1_s1 <= angle_1;
			ang2_s1 <= angle_2;
			rate1_s[dpd_pkg::T_IN] <= rate_1;
			rate2_s[dpd_pkg::T_IN] <= rate_2;
			torq1_s[dpd_pkg::T_IN] <= torque_1;
			torq2_s[dpd_pkg::T_IN] <= torque_2;
			for (int t = dpd_pkg::T_IN + 1; t <= dpd_pkg::T_OUT; t++) begin
				rate1_s[t] <= rate1_s[t-1];
				rate2_s[t] <= rate2_s[t-1];
			end
			for (int t = dpd_pkg::T_IN + 1; t <= dpd_pkg::T_P1; t++) begin
				torq1_s[t] <= torq1_s[t-1];
				torq2_s[t] <= torq2_s[t-1];
			end
			ph1_s2 <= dpd_pkg::to_phase(ang1_s1);
			ph2_s2 <= dpd_pkg::to_phase(ang2_s1);
		end
	end

	// Squared rates, formed early and carried to the second level of products.
	dpd_pkg::wide_t sq1_o;
	dpd_pkg::wide_t sq2_o;
	dpd_pkg::wide_t sq1_s [dpd_pkg::T_SQ+1:dpd_pkg::T_P1];
	dpd_pkg::wide_t sq2_s [dpd_pkg::T_SQ+1:dpd_pkg::T_P1];

	dpd_qmul u_sq1 (
		.clk(clk), .en(en),
		.a(34'(rate1_s[dpd_pkg::T_IN])), .b(64'(rate1_s[dpd_pkg::T_IN])),
		.y(sq1_o)
	);

	dpd_qmul u_sq2 (
		.clk(clk), .en(en),
		.a(34'(rate2_s[dpd_pkg::T_IN])), .b(64'(rate2_s[dpd_pkg::T_IN])),
		.y(sq2_o)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sq1_s[dpd_pkg::T_SQ+1] <= sq1_o;
			sq2_s[dpd_pkg::T_SQ+1] <= sq2_o;
			for (int t = dpd_pkg::T_SQ + 2; t <= dpd_pkg::T_P1; t++) begin
				sq1_s[t] <= sq1_s[t-1];
				sq2_s[t] <= sq2_s[t-1];
			end
		end
	end

	// Sine and cosine of q1, q2 and of q1-q2 (phase difference wraps).
	dpd_pkg::trig_t s1_o, c1_o, s2_o, c2_o, sd_o, cd_o;
	logic [15:0] phd;

	assign phd = ph1_s2 - ph2_s2;

	dpd_sincos u_sc1 (.clk(clk), .en(en), .phase(ph1_s2), .sin_val(s1_o), .cos_val(c1_o));
	dpd_sincos u_sc2 (.clk(clk), .en(en), .phase(ph2_s2), .sin_val(s2_o), .cos_val(c2_o));
	dpd_sincos u_scd (.clk(clk), .en(en), .phase(phd), .sin_val(sd_o), .cos_val(cd_o));

	// First level of products: gravity terms, Coriolis factors, c*c and m2*c.
	dpd_pkg::wide_t cc_o, g1_o, g2_o, pa_o, pb_o, m2c_o;

	dpd_qmul u_cc (.clk(clk), .en(en), .a(34'(cd_o)), .b(64'(cd_o)), .y(cc_o));
	dpd_qmul u_g1 (.clk(clk), .en(en), .a(34'(s1_o)), .b({34'd0, msumg_q}), .y(g1_o));
	dpd_qmul u_g2 (.clk(clk), .en(en), .a(34'(s2_o)), .b({35'd0, m2g_q}), .y(g2_o));
	dpd_qmul u_pa (.clk(clk), .en(en), .a(34'(sd_o)), .b({31'd0, m2l2_q}), .y(pa_o));
	dpd_qmul u_pb (.clk(clk), .en(en), .a(34'(sd_o)), .b({31'd0, m2l1_q}), .y(pb_o));
	dpd_qmul u_m2c (.clk(clk), .en(en), .a(34'(cd_o)), .b({40'd0, mass_two_q}), .y(m2c_o));

	// Torque minus gravity, then held one more stage to meet the rate terms.
	dpd_pkg::wide_t r1a_s10, r2a_s10, r1a_s11, r2a_s11;
	dpd_pkg::trig_t cd_s [dpd_pkg::T_SC+1:dpd_pkg::T_RHS];
	dpd_pkg::wide_t m2c_s [dpd_pkg::T_P1+1:dpd_pkg::T_RHS];

	always_ff @(posedge clk) begin
		if (en) begin
			r1a_s10 <= dpd_pkg::sub_sat(64'(torq1_s[dpd_pkg::T_P1]), g1_o);
			r2a_s10 <= dpd_pkg::sub_sat(64'(torq2_s[dpd_pkg::T_P1]), g2_o);
			r1a_s11 <= r1a_s10;
			r2a_s11 <= r2a_s10;
			cd_s[dpd_pkg::T_SC+1] <= cd_o;
			for (int t = dpd_pkg::T_SC + 2; t <= dpd_pkg::T_RHS; t++) begin
				cd_s[t] <= cd_s[t-1];
			end
			m2c_s[dpd_pkg::T_P1+1] <= m2c_o;
			for (int t = dpd_pkg::T_P1 + 2; t <= dpd_pkg::T_RHS; t++) begin
				m2c_s[t] <= m2c_s[t-1];
			end
		end
	end

	// Second level: rate-squared terms and m2*c^2.
	dpd_pkg::wide_t pk_o, t1_o, t2_o;

	dpd_qmul u_pk (.clk(clk), .en(en), .a(cc_o[33:0]), .b({40'd0, mass_two_q}), .y(pk_o));
	dpd_qmul u_t1 (
		.clk(clk), .en(en), .a(pa_o[33:0]), .b(sq2_s[dpd_pkg::T_P1]), .y(t1_o)
	);
	dpd_qmul u_t2 (
		.clk(clk), .en(en), .a(pb_o[33:0]), .b(sq1_s[dpd_pkg::T_P1]), .y(t2_o)
	);

	// Right-hand sides and the reduced inertia k, which is never negative.
	dpd_pkg::wide_t rhs1_s12, rhs2_s12, k_s12;
	dpd_pkg::wide_t rhs1_s [dpd_pkg::T_RHS+1:dpd_pkg::T_P3];

	always_ff @(posedge clk) begin
		if (en) begin
			rhs1_s12 <= dpd_pkg::sub_sat(r1a_s11, t1_o);
			rhs2_s12 <= dpd_pkg::add_sat(r2a_s11, t2_o);
			k_s12 <= dpd_pkg::sub_sat({39'd0, msum_q}, pk_o);
			rhs1_s[dpd_pkg::T_RHS+1] <= rhs1_s12;
			for (int t = dpd_pkg::T_RHS + 2; t <= dpd_pkg::T_P3; t++) begin
				rhs1_s[t] <= rhs1_s[t-1];
			end
		end
	end

	// Third level: the terms of both numerators and both denominators.
	dpd_pkg::wide_t crhs2_o, msr_o, mcr_o, d1_o, d2_o;

	dpd_qmul u_crhs2 (
		.clk(clk), .en(en), .a(34'(cd_s[dpd_pkg::T_RHS])), .b(rhs2_s12), .y(crhs2_o)
	);
	dpd_qmul u_msr (.clk(clk), .en(en), .a({9'd0, msum_q}), .b(rhs2_s12), .y(msr_o));
	dpd_qmul u_mcr (
		.clk(clk), .en(en), .a(m2c_s[dpd_pkg::T_RHS][33:0]), .b(rhs1_s12), .y(mcr_o)
	);
	dpd_qmul u_d1 (.clk(clk), .en(en), .a({10'd0, length_one_q}), .b(k_s12), .y(d1_o));
	dpd_qmul u_d2 (.clk(clk), .en(en), .a(k_s12[33:0]), .b({31'd0, m2l2_q}), .y(d2_o));

	dpd_pkg::wide_t num1_s15, num2_s15, den1_s15, den2_s15;

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s15 <= dpd_pkg::sub_sat(rhs1_s[dpd_pkg::T_P3], crhs2_o);
			num2_s15 <= dpd_pkg::sub_sat(msr_o, mcr_o);
			den1_s15 <= d1_o;
			den2_s15 <= d2_o;
		end
	end

	// The two divides run side by side and land in the output stage.
	dpd_div u_div1 (.clk(clk), .en(en), .num(num1_s15), .den(den1_s15), .quo(accel_1));
	dpd_div u_div2 (.clk(clk), .en(en), .num(num2_s15), .den(den2_s15), .quo(accel_2));

	assign out_rate_1 = rate1_s[dpd_pkg::T_OUT];
	assign out_rate_2 = rate2_s[dpd_pkg::T_OUT];

	// A stall freezes the valid chain, so no beat is dropped or doubled.
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> vld_s == $past(vld_s))
		else $error("valid chain moved during a stall");

	// An accepted beat occupies the first stage on the next cycle.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s[dpd_pkg::T_IN])
		else $error("accepted beat missing from the first stage");

	// A waiting output blocks the input side.
	a_wait_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalls");

	// The first stage captures the rate of the accepted beat.
	a_rate_capture: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> rate1_s[dpd_pkg::T_IN] == $past(rate_1))
		else $error("first stage rate differs from accepted beat");

endmodule

>>> tb/sv/tb_double_pendulum_derivative.sv
`timescale 1ns / 1ps

// Self-checking bench for the double pendulum derivative block. A driver
// pushes pendulum states from a queue with random gaps, a monitor takes
// result beats with random stalls, and a fixed-point predictor computes the
// expected derivative for every accepted input beat.
module tb_double_pendulum_derivative;

	localparam int LATENCY = 49;
	localparam longint WM = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [31:0] a1, r1, a2, r2, t1, t2;
	} pstate_t;

	typedef struct packed {
		logic signed [31:0] r1, acc1, r2, acc2;
	} deriv_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] angle_1 = '0, rate_1 = '0, angle_2 = '0;
	logic signed [31:0] rate_2 = '0, torque_1 = '0, torque_2 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] out_rate_1, accel_1, out_rate_2, accel_2;
	logic cfg_we = 1'b0;
	dpd_pkg::cfg_index_t cfg_index = dpd_pkg::CFG_LENGTH_ONE;
	logic [23:0] cfg_data = '0;

	double_pendulum_derivative dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copies of the length and mass registers.
	longint len1 = 65536, len2 = 65536, mas1 = 65536, mas2 = 65536;

	pstate_t pending[$];
	deriv_t expected_derivs[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;

	function automatic longint clamp_w(longint v);
		if (v > WM) return WM;
		if (v < -WM) return -WM;
		return v;
	endfunction

	function automatic longint sub_w(longint a, longint b);
		return clamp_w(clamp_w(a) - clamp_w(b));
	endfunction

	function automatic longint add_w(longint a, longint b);
		return clamp_w(clamp_w(a) + clamp_w(b));
	endfunction

	// Exact product, rounded half away from zero, saturated.
	function automatic longint qprod(longint a, longint b);
		logic [127:0] p;
		logic [127:0] r;
		bit neg;
		logic [63:0] x, y;
		a = clamp_w(a);
		b = clamp_w(b);
		neg = (a < 0) != (b < 0);
		x = (a < 0) ? -a : a;
		y = (b < 0) ? -b : b;
		p = 128'(x) * 128'(y);
		r = (p + 128'h8000) >> 16;
		if (r > 128'(WM)) r = 128'(WM);
		return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
	endfunction

	// Truncating quotient in Q16.16, saturated to 32 bits.
	function automatic longint qquot(longint num, longint den);
		logic [127:0] n, d, q;
		bit neg;
		num = clamp_w(num);
		den = clamp_w(den);
		if (num == 0) return 0;
		if (den == 0) return (num > 0) ? 2147483647 : -2147483648;
		neg = (num < 0) != (den < 0);
		n = 128'((num < 0) ? -num : num) << 16;
		d = 128'((den < 0) ? -den : den);
		q = n / d;
		if (neg) return (q > 128'h8000_0000) ? -2147483648 : -longint'(q[63:0]);
		return (q > 128'h7FFF_FFFF) ? 2147483647 : longint'(q[63:0]);
	endfunction

	function automatic logic [15:0] phase_of(logic signed [31:0] ang);
		logic [63:0] p;
		p = 64'(longint'(ang) * 64'sd683565276) + 64'h8000_0000;
		return p[47:32];
	endfunction

	function automatic longint quarter_wave(logic [63:0] t);
		logic [63:0] x, x2, p, v;
		x = t << 16;
		x2 = (x * x) >> 30;
		p = 64'd85569306 - ((x2 * 64'd5027025) >> 30);
		p = 64'd693598668 - ((x2 * p) >> 30);
		p = 64'd1686629713 - ((x2 * p) >> 30);
		v = (x * p) >> 30;
		v = (v + 64'h2000) >> 14;
		if (v > 64'd65536) v = 64'd65536;
		return longint'(v);
	endfunction

	task automatic sincos(input logic [15:0] ph, output longint s, output longint c);
		longint a, b;
		a = quarter_wave(64'(ph[13:0]));
		b = quarter_wave(64'd16384 - 64'(ph[13:0]));
		case (ph[15:14])
			2'd0: begin s = a; c = b; end
			2'd1: begin s = b; c = -a; end
			2'd2: begin s = -a; c = -b; end
			default: begin s = -b; c = a; end
		endcase
	endtask

	task automatic predict_derivative(input pstate_t st, output deriv_t d);
		longint s1, c1, s2, c2, s, c, msum, k, m2l2, rhs1, rhs2, num1, num2;
		logic [15:0] p1, p2;
		p1 = phase_of(st.a1);
		p2 = phase_of(st.a2);
		sincos(p1, s1, c1);
		sincos(p2, s2, c2);
		sincos(p1 - p2, s, c);
		msum = mas1 + mas2;
		m2l2 = qprod(mas2, len2);
		k = sub_w(msum, qprod(mas2, qprod(c, c)));
		rhs1 = sub_w(st.t1, qprod(qprod(msum, dpd_pkg::GRAVITY), s1));
		rhs1 = sub_w(rhs1, qprod(qprod(m2l2, s), qprod(st.r2, st.r2)));
		rhs2 = sub_w(st.t2, qprod(qprod(mas2, dpd_pkg::GRAVITY), s2));
		rhs2 = add_w(rhs2, qprod(qprod(qprod(mas2, len1), s), qprod(st.r1, st.r1)));
		num1 = sub_w(rhs1, qprod(c, rhs2));
		num2 = sub_w(qprod(msum, rhs2), qprod(qprod(mas2, c), rhs1));
		d.r1 = st.r1;
		d.acc1 = 32'(qquot(num1, qprod(len1, k)));
		d.r2 = st.r2;
		d.acc2 = 32'(qquot(num2, qprod(m2l2, k)));
	endtask

	// The driver presents the head of the queue and holds it until the beat
	// is taken. The prediction is made at the accepting edge, so the shadow
	// registers always match what the block used.
	always @(posedge clk) begin
		pstate_t st;
		deriv_t d;
		cycles <= cycles + 1;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				st = pending.pop_front();
				predict_derivative(st, d);
				expected_derivs.push_back(d);
			end
			if ((!in_valid || in_ready) && pending.size() > 0) begin
				if (calm || $urandom_range(99) >= 12) begin
					st = pending[0];
					in_valid <= 1'b1;
					{angle_1, rate_1, angle_2, rate_2, torque_1, torque_2} <= st;
				end else begin
					in_valid <= 1'b0;
				end
			end else if (in_valid && in_ready) begin
				in_valid <= 1'b0;
			end
			out_ready <= calm || ($urandom_range(99) >= 12);
		end
	end

	// The monitor compares each taken result beat with the oldest prediction.
	always @(posedge clk) begin
		deriv_t exp_d;
		if (arst_n && out_valid && out_ready) begin
			if (expected_derivs.size() == 0) begin
				$display("%0t: unexpected result beat rate1=%h acc1=%h", $time,
					out_rate_1, accel_1);
				errors++;
			end else begin
				exp_d = expected_derivs.pop_front();
				if (out_rate_1 !== exp_d.r1) begin
					$display("%0t: out_rate_1 expected %h actual %h", $time, exp_d.r1, out_rate_1);
					errors++;
				end
				if (accel_1 !== exp_d.acc1) begin
					$display("%0t: accel_1 expected %h actual %h", $time, exp_d.acc1, accel_1);
					errors++;
				end
				if (out_rate_2 !== exp_d.r2) begin
					$display("%0t: out_rate_2 expected %h actual %h", $time, exp_d.r2, out_rate_2);
					errors++;
				end
				if (accel_2 !== exp_d.acc2) begin
					$display("%0t: accel_2 expected %h actual %h", $time, exp_d.acc2, accel_2);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'(signed'($urandom_range(65535)) - 32768) <<< 4;
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return 32'($urandom_range(2 * 411775)) - 32'sd411775;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [23:0] rand_reg();
		case ($urandom_range(4))
			0: return 24'd1;
			1: return 24'hFF_FFFF;
			2: return 24'($urandom_range(262144, 8192));
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic write_reg(input dpd_pkg::cfg_index_t idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dpd_pkg::CFG_LENGTH_ONE: len1 = val;
			dpd_pkg::CFG_LENGTH_TWO: len2 = val;
			dpd_pkg::CFG_MASS_ONE: mas1 = val;
			default: mas2 = val;
		endcase
	endtask

	task automatic drain();
		while (pending.size() > 0 || in_valid || expected_derivs.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic queue_random(input int n);
		pstate_t st;
		repeat (n) begin
			st = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
			pending.push_back(st);
		end
	endtask

	initial begin
		pstate_t st;
		logic signed [31:0] ext[4];
		ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: field extremes and zeros, quarter-turn and half-turn angles, all-ones state.
		for (int i = 0; i < 4; i++) begin
			st = {ext[i], ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[i], ext[(i + 3) % 4]};
			pending.push_back(st);
		end
		pending.push_back({32'sd102944, 32'sd0, -32'sd102944, 32'sd0, 32'sd0, 32'sd0});
		pending.push_back({32'sd205887, 32'sd65536, 32'sd0, -32'sd65536, 32'sd0, 32'sd0});
		pending.push_back('1);
		drain();
		// Zero-sized denominators come from the smallest registers.
		write_reg(dpd_pkg::CFG_LENGTH_ONE, 24'd1);
		write_reg(dpd_pkg::CFG_LENGTH_TWO, 24'd1);
		write_reg(dpd_pkg::CFG_MASS_ONE, 24'd1);
		write_reg(dpd_pkg::CFG_MASS_TWO, 24'd1);
		pending.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
		pending.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, -32'sd65536});
		queue_random(8);
		drain();
		write_reg(dpd_pkg::CFG_LENGTH_ONE, 24'hFF_FFFF);
		write_reg(dpd_pkg::CFG_LENGTH_TWO, 24'hFF_FFFF);
		write_reg(dpd_pkg::CFG_MASS_ONE, 24'hFF_FFFF);
		write_reg(dpd_pkg::CFG_MASS_TWO, 24'hFF_FFFF);
		queue_random(8);
		drain();
		// Random phases, each under a fresh register setting.
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(dpd_pkg::CFG_LENGTH_ONE, rand_reg());
			write_reg(dpd_pkg::CFG_LENGTH_TWO, rand_reg());
			write_reg(dpd_pkg::CFG_MASS_ONE, rand_reg());
			write_reg(dpd_pkg::CFG_MASS_TWO, rand_reg());
			calm = (ph == 4);
			queue_random(128);
			drain();
		end
		calm = 1'b0;
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> double_pendulum_derivative.f
src/dpd_pkg.sv
src/dpd_qmul.sv
src/dpd_sincos.sv
src/dpd_div.sv
src/double_pendulum_derivative.sv
tb/sv/tb_double_pendulum_derivative.sv
